FILE: rtl/dlb_pkg.sv
`timescale 1ns / 1ps
// Package for the delayed dry/wet blend: sizes, fixed-point constants and codes.
// Used by delayed_dry_wet_blend_with_ramps; depends on nothing else.
package dlb_pkg;

	localparam int DELAY_DEPTH = 131072;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	// The fade is taken as a shift, so the fade length is a power of two.
	localparam int FADE_FRAMES = 128;
	localparam int FADE_SHIFT  = $clog2(FADE_FRAMES);
	localparam int TC_W        = $clog2(2 * FADE_FRAMES + 1);

	localparam int SMP_W  = 24;
	localparam int LAT_W  = 17;
	localparam int STR_W  = 17;
	localparam int GAIN_W = 21;
	localparam int RAMP_W = 13;
	localparam int MUL_W  = 26;
	localparam int DIV_W  = GAIN_W;
	localparam int DIV_CW = $clog2(DIV_W);

	localparam logic [STR_W-1:0]  UNITY     = STR_W'(65536);
	localparam logic [GAIN_W-1:0] GAIN_UNIT = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] GAIN_MAX  = GAIN_W'(1048576);
	localparam logic [STR_W-1:0]  WSTEP     = STR_W'(65536 / FADE_FRAMES);
	localparam logic [RAMP_W-1:0] RAMP_RST  = RAMP_W'(240);

	localparam logic OP_AUDIO  = 1'b0;
	localparam logic OP_COMMIT = 1'b1;

endpackage

FILE: rtl/delayed_dry_wet_blend_with_ramps.sv
`timescale 1ns / 1ps
// Top level of the delayed dry/wet blend with latency crossfade and parameter ramps.
// Depends on dlb_pkg; holds the dry delay memory and the shared multiply sequencer.

// A commit word (op high) leaves the input ready and produces no result. An audio word
// closes the input from acceptance until its result enters the output register. The time is
// set by one shared 26 by 26 bit multiplier: it forms the mix once per frame, then each
// channel runs through eight states in which it is used five times. Each strength or gain
// ramp that starts in a frame adds a pass through the bit-serial step divider. The next
// word is accepted as soon as the result has moved into the output register, so a result
// may wait there while the following frame is already being worked on. The dry delay is a
// single memory with one write and one registered read per frame; entries not yet written
// since reset read as zero through a wrap flag on the write pointer, so there is no
// clearing pass. The configuration port is always ready and should be written only while
// the block is idle.
module delayed_dry_wet_blend_with_ramps
	import dlb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [RAMP_W-1:0]        ramp_frames,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     op,
	input  logic signed [SMP_W-1:0]  dry_left,
	input  logic signed [SMP_W-1:0]  dry_right,
	input  logic signed [SMP_W-1:0]  wet_left,
	input  logic signed [SMP_W-1:0]  wet_right,
	input  logic                     wet_enable,
	input  logic [STR_W-1:0]         strength_target,
	input  logic [GAIN_W-1:0]        gain_target,
	input  logic [LAT_W-1:0]         new_latency,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [SMP_W-1:0]  out_left,
	output logic signed [SMP_W-1:0]  out_right,
	output logic                     wet_silent
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_RT_S, ST_DIV_S, ST_RT_G, ST_DIV_G, ST_ADV, ST_MIX, ST_MIXW,
		ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_FIN
	} state_t;

	state_t state_q;

	// Control and ramp state.
	logic [RAMP_W-1:0]        ramp_q;
	logic [ADDR_W-1:0]        wp_q;
	logic                     wrapped_q;
	logic [LAT_W-1:0]         cur_lat_q, prev_lat_q;
	logic [TC_W-1:0]          tc_q;
	logic [STR_W-1:0]         wet_q;
	logic [STR_W-1:0]         s_lvl_q, s_goal_q;
	logic signed [STR_W:0]    s_step_q;
	logic [RAMP_W-1:0]        s_cnt_q;
	logic                     s_rdy_q;
	logic [GAIN_W-1:0]        g_lvl_q, g_goal_q;
	logic signed [GAIN_W:0]   g_step_q;
	logic [RAMP_W-1:0]        g_cnt_q;
	logic                     g_rdy_q;
	logic                     ch_q;
	logic                     out_valid_q;

	// Divider state.
	logic [DIV_W-1:0]         div_num_q;
	logic [RAMP_W-1:0]        div_rem_q, div_n_q;
	logic [DIV_CW-1:0]        div_cnt_q;
	logic                     div_neg_q;

	// Datapath registers.
	logic signed [SMP_W-1:0]  dry_l_q, dry_r_q, wet_l_q, wet_r_q;
	logic                     wet_en_q;
	logic [STR_W-1:0]         st_q;
	logic [GAIN_W-1:0]        gt_q;
	logic [2*SMP_W-1:0]       rd_q;
	logic                     rd_fwd_q, rd_zero_q;
	logic signed [SMP_W-1:0]  dly_l_q, dly_r_q;
	logic [STR_W-1:0]         fade_q, mix_q;
	logic signed [2*MUL_W-1:0] prod_q;
	logic signed [41:0]       b_q;
	logic signed [63:0]       acc_q;
	logic signed [46:0]       g_q;
	logic signed [SMP_W-1:0]  res_l_q, res_r_q;
	logic signed [SMP_W-1:0]  out_l_q, out_r_q;
	logic                     silent_q;

	logic [2*SMP_W-1:0]       mem [DELAY_DEPTH];

	// Combinational helpers.
	logic                     in_acc;
	logic [RAMP_W-1:0]        ramp_n;
	logic [STR_W-1:0]         st_clamp;
	logic [GAIN_W-1:0]        gt_clamp;
	logic signed [GAIN_W:0]   s_diff, g_diff, s_abs, g_abs;
	logic [RAMP_W:0]          div_t;
	logic                     div_ge;
	logic [RAMP_W-1:0]        div_rem_nx;
	logic [DIV_W-1:0]         div_num_nx;
	logic [STR_W-1:0]         wet_nx;
	logic signed [STR_W+1:0]  s_sum;
	logic signed [GAIN_W+1:0] g_sum;
	logic [TC_W-1:0]          fade_num;
	logic [STR_W-1:0]         fade_nx;
	logic [LAT_W-1:0]         dly_sel;
	logic [ADDR_W-1:0]        dly_cl, rp;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [SMP_W-1:0]  cur_dry, cur_wet;
	logic signed [SMP_W:0]    diff_c;
	logic signed [63:0]       g_sum64, o_sum64;
	logic signed [31:0]       o_val;
	logic signed [SMP_W-1:0]  o_sat;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign out_left   = out_l_q;
	assign out_right  = out_r_q;
	assign wet_silent = silent_q;

	assign ramp_n   = (ramp_q == '0) ? RAMP_W'(1) : ramp_q;
	assign st_clamp = (strength_target > UNITY) ? UNITY : strength_target;
	assign gt_clamp = (gain_target > GAIN_MAX) ? GAIN_MAX : gain_target;

	// Distance to a new goal; the step is its magnitude divided by the ramp length,
	// with the sign put back afterwards so that it truncates toward zero.
	assign s_diff = $signed({{(GAIN_W+1-STR_W){1'b0}}, st_q})
		- $signed({{(GAIN_W+1-STR_W){1'b0}}, s_lvl_q});
	assign g_diff = $signed({1'b0, gt_q}) - $signed({1'b0, g_lvl_q});
	assign s_abs  = s_diff[GAIN_W] ? -s_diff : s_diff;
	assign g_abs  = g_diff[GAIN_W] ? -g_diff : g_diff;

	// One restoring division step per cycle.
	assign div_t      = {div_rem_q, div_num_q[DIV_W-1]};
	assign div_ge     = div_t >= {1'b0, div_n_q};
	assign div_rem_nx = div_ge ? RAMP_W'(div_t - {1'b0, div_n_q}) : div_t[RAMP_W-1:0];
	assign div_num_nx = {div_num_q[DIV_W-2:0], div_ge};

	// Wet level moves one fade step toward its target and stops on it.
	always_comb begin
		wet_nx = wet_q;
		if (wet_en_q && wet_q < UNITY) begin
			wet_nx = (UNITY - wet_q > WSTEP) ? wet_q + WSTEP : UNITY;
		end else if (!wet_en_q && wet_q != '0) begin
			wet_nx = (wet_q > WSTEP) ? wet_q - WSTEP : '0;
		end
	end

	assign s_sum = $signed({2'b00, s_lvl_q}) + (STR_W+2)'(s_step_q);
	assign g_sum = $signed({2'b00, g_lvl_q}) + (GAIN_W+2)'(g_step_q);

	// Crossfade gain: the first half of a transition fades out at the old delay,
	// the second half fades in at the new one.
	assign fade_num = (tc_q > TC_W'(FADE_FRAMES)) ? tc_q - TC_W'(FADE_FRAMES)
		: TC_W'(FADE_FRAMES) - tc_q;
	assign fade_nx  = (tc_q == '0) ? UNITY
		: STR_W'((32'(fade_num) << 16) >> FADE_SHIFT);

	assign dly_sel = (tc_q > TC_W'(FADE_FRAMES)) ? prev_lat_q : cur_lat_q;
	assign dly_cl  = (32'(dly_sel) >= 32'(DELAY_DEPTH)) ? ADDR_W'(DELAY_DEPTH - 1)
		: ADDR_W'(dly_sel);
	assign rp      = (wp_q >= dly_cl) ? wp_q - dly_cl
		: ADDR_W'(32'(DELAY_DEPTH) + 32'(wp_q) - 32'(dly_cl));

	assign cur_dry = ch_q ? dly_r_q : dly_l_q;
	assign cur_wet = ch_q ? wet_r_q : wet_l_q;
	assign diff_c  = (SMP_W+1)'(cur_wet) - (SMP_W+1)'(cur_dry);

	// Operand selection for the shared multiplier; its product is registered.
	always_comb begin
		case (state_q)
			ST_MIX: begin
				mul_a = $signed({{(MUL_W-STR_W){1'b0}}, wet_q});
				mul_b = $signed({{(MUL_W-STR_W){1'b0}}, s_lvl_q});
			end
			ST_C0: begin
				mul_a = $signed({{(MUL_W-STR_W){1'b0}}, mix_q});
				mul_b = MUL_W'(diff_c);
			end
			ST_C2: begin
				mul_a = MUL_W'($signed(b_q[41:21]));
				mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, g_lvl_q});
			end
			ST_C3: begin
				mul_a = $signed({{(MUL_W-21){1'b0}}, b_q[20:0]});
				mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, g_lvl_q});
			end
			ST_C5: begin
				mul_a = MUL_W'($signed(g_q[46:24]));
				mul_b = $signed({{(MUL_W-STR_W){1'b0}}, fade_q});
			end
			ST_C6: begin
				mul_a = $signed({{(MUL_W-24){1'b0}}, g_q[23:0]});
				mul_b = $signed({{(MUL_W-STR_W){1'b0}}, fade_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign g_sum64 = acc_q + 64'(prod_q) + 64'sd32768;
	assign o_sum64 = acc_q + 64'(prod_q) + 64'sh80000000;
	assign o_val   = o_sum64[63:32];
	assign o_sat   = (o_val > 32'sd8388607) ? SMP_W'(24'h7FFFFF)
		: (o_val < -32'sd8388608) ? SMP_W'(24'h800000) : SMP_W'(o_val);

	// Dry delay memory: one write and one registered read per frame.
	always_ff @(posedge clk) begin
		if (state_q == ST_ADV) begin
			mem[wp_q] <= {dry_l_q, dry_r_q};
			rd_q      <= mem[rp];
		end
	end

	// Sequencer with its control and ramp state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ramp_q      <= RAMP_RST;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			cur_lat_q   <= '0;
			prev_lat_q  <= '0;
			tc_q        <= '0;
			wet_q       <= '0;
			s_lvl_q     <= '0;
			s_goal_q    <= '0;
			s_step_q    <= '0;
			s_cnt_q     <= '0;
			s_rdy_q     <= 1'b0;
			g_lvl_q     <= GAIN_UNIT;
			g_goal_q    <= GAIN_UNIT;
			g_step_q    <= '0;
			g_cnt_q     <= '0;
			g_rdy_q     <= 1'b0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ramp_q <= ramp_frames;
			end
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == OP_COMMIT) begin
							prev_lat_q <= cur_lat_q;
							cur_lat_q  <= new_latency;
							tc_q       <= (cur_lat_q == new_latency) ? '0
								: TC_W'(2 * FADE_FRAMES);
						end else begin
							state_q <= ST_RT_S;
						end
					end
				end
				ST_RT_S: begin
					if (!s_rdy_q) begin
						s_lvl_q  <= st_q;
						s_goal_q <= st_q;
						s_step_q <= '0;
						s_cnt_q  <= '0;
						s_rdy_q  <= 1'b1;
						state_q  <= ST_RT_G;
					end else if (st_q != s_goal_q) begin
						s_goal_q  <= st_q;
						s_cnt_q   <= ramp_n;
						div_num_q <= DIV_W'(s_abs);
						div_neg_q <= s_diff[GAIN_W];
						div_rem_q <= '0;
						div_n_q   <= ramp_n;
						div_cnt_q <= DIV_CW'(DIV_W - 1);
						state_q   <= ST_DIV_S;
					end else begin
						state_q <= ST_RT_G;
					end
				end
				ST_DIV_S: begin
					div_num_q <= div_num_nx;
					div_rem_q <= div_rem_nx;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						s_step_q <= div_neg_q ? -(STR_W+1)'(div_num_nx)
							: (STR_W+1)'(div_num_nx);
						state_q  <= ST_RT_G;
					end
				end
				ST_RT_G: begin
					if (!g_rdy_q) begin
						g_lvl_q  <= gt_q;
						g_goal_q <= gt_q;
						g_step_q <= '0;
						g_cnt_q  <= '0;
						g_rdy_q  <= 1'b1;
						state_q  <= ST_ADV;
					end else if (gt_q != g_goal_q) begin
						g_goal_q  <= gt_q;
						g_cnt_q   <= ramp_n;
						div_num_q <= DIV_W'(g_abs);
						div_neg_q <= g_diff[GAIN_W];
						div_rem_q <= '0;
						div_n_q   <= ramp_n;
						div_cnt_q <= DIV_CW'(DIV_W - 1);
						state_q   <= ST_DIV_G;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_DIV_G: begin
					div_num_q <= div_num_nx;
					div_rem_q <= div_rem_nx;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						g_step_q <= div_neg_q ? -(GAIN_W+1)'(div_num_nx)
							: (GAIN_W+1)'(div_num_nx);
						state_q  <= ST_ADV;
					end
				end
				ST_ADV: begin
					wet_q <= wet_nx;
					if (s_cnt_q != '0) begin
						s_cnt_q <= s_cnt_q - 1'b1;
						if (s_cnt_q == RAMP_W'(1)) begin
							s_lvl_q  <= s_goal_q;
							s_step_q <= '0;
						end else begin
							s_lvl_q <= STR_W'(s_sum);
						end
					end
					if (g_cnt_q != '0) begin
						g_cnt_q <= g_cnt_q - 1'b1;
						if (g_cnt_q == RAMP_W'(1)) begin
							g_lvl_q  <= g_goal_q;
							g_step_q <= '0;
						end else begin
							g_lvl_q <= GAIN_W'(g_sum);
						end
					end
					if (32'(wp_q) == 32'(DELAY_DEPTH - 1)) begin
						wp_q      <= '0;
						wrapped_q <= 1'b1;
					end else begin
						wp_q <= wp_q + 1'b1;
					end
					if (tc_q != '0) begin
						tc_q <= tc_q - 1'b1;
					end
					state_q <= ST_MIX;
				end
				ST_MIX:  state_q <= ST_MIXW;
				ST_MIXW: begin
					ch_q    <= 1'b0;
					state_q <= ST_C0;
				end
				ST_C0: state_q <= ST_C1;
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= ST_C4;
				ST_C4: state_q <= ST_C5;
				ST_C5: state_q <= ST_C6;
				ST_C6: state_q <= ST_C7;
				ST_C7: begin
					if (ch_q) begin
						state_q <= ST_FIN;
					end else begin
						ch_q    <= 1'b1;
						state_q <= ST_C0;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_acc) begin
			dry_l_q  <= dry_left;
			dry_r_q  <= dry_right;
			wet_l_q  <= wet_left;
			wet_r_q  <= wet_right;
			wet_en_q <= wet_enable;
			st_q     <= st_clamp;
			gt_q     <= gt_clamp;
		end
		case (state_q)
			ST_ADV: begin
				fade_q    <= fade_nx;
				rd_fwd_q  <= (rp == wp_q);
				rd_zero_q <= !wrapped_q && (rp > wp_q);
			end
			ST_MIX: begin
				// A zero delay returns this frame's own dry word.
				dly_l_q <= rd_zero_q ? '0 : rd_fwd_q ? dry_l_q : rd_q[2*SMP_W-1:SMP_W];
				dly_r_q <= rd_zero_q ? '0 : rd_fwd_q ? dry_r_q : rd_q[SMP_W-1:0];
			end
			ST_MIXW: mix_q <= STR_W'((prod_q + 52'sd32768) >>> 16);
			ST_C1:   b_q <= $signed({{2{cur_dry[SMP_W-1]}}, cur_dry, 16'b0})
				+ 42'(prod_q);
			ST_C3:   acc_q <= 64'(prod_q) <<< 21;
			ST_C4:   g_q <= g_sum64[62:16];
			ST_C6:   acc_q <= 64'(prod_q) <<< 24;
			ST_C7: begin
				if (ch_q) begin
					res_r_q <= o_sat;
				end else begin
					res_l_q <= o_sat;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_l_q  <= res_l_q;
					out_r_q  <= res_r_q;
					silent_q <= (wet_q == '0);
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/dlb_chk.sv
`timescale 1ns / 1ps
// Port-level checker for delayed_dry_wet_blend_with_ramps, attached by bind.
// Depends on dlb_pkg for field widths.
module dlb_chk
	import dlb_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cfg_valid,
	input logic                    cfg_ready,
	input logic [RAMP_W-1:0]       ramp_frames,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    op,
	input logic signed [SMP_W-1:0] dry_left,
	input logic signed [SMP_W-1:0] dry_right,
	input logic signed [SMP_W-1:0] wet_left,
	input logic signed [SMP_W-1:0] wet_right,
	input logic                    wet_enable,
	input logic [STR_W-1:0]        strength_target,
	input logic [GAIN_W-1:0]       gain_target,
	input logic [LAT_W-1:0]        new_latency,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [SMP_W-1:0] out_left,
	input logic signed [SMP_W-1:0] out_right,
	input logic                    wet_silent
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left)
			&& $stable(out_right) && $stable(wet_silent))
		else $error("result word changed while stalled");

	// An audio word keeps the input closed while it is worked on.
	a_audio_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_AUDIO |=> !in_ready)
		else $error("input reopened straight after an audio word");

	// A commit word leaves the input open.
	a_commit_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_COMMIT |=> in_ready)
		else $error("commit word held the input");

	// A new result only appears after the input was closed for the work.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

endmodule

bind delayed_dry_wet_blend_with_ramps dlb_chk u_dlb_chk (.*);
